// ----- hw/rtl/wgsg_pkg.sv -----
// Package for the wave gait swing generator: FSM states, divider command and
// status structs, register indexes, reset values and sine table constants.
// No dependencies.
`default_nettype none

package wgsg_pkg;

  // Field widths
  localparam int CYCLE_W   = 10;   // gait length register and tick counter
  localparam int CFG_W     = 16;   // widest configuration register
  localparam int VEL_W     = 16;
  localparam int LEG_W     = 3;
  localparam int FOOT_XY_W = 24;
  localparam int FOOT_Z_W  = 16;
  localparam int SWING_W   = 8;    // gait length / 6 never exceeds 170
  localparam int PROG_FRAC = 16;   // progress is Q0.16
  localparam int PROG_W    = PROG_FRAC + 1;  // progress reaches 1.0

  // Configuration register indexes
  localparam logic [1:0] CFG_GAIT_LEN  = 2'd0;
  localparam logic [1:0] CFG_TICK_DUR  = 2'd1;
  localparam logic [1:0] CFG_LIFT_PEAK = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CYCLE_W-1:0] GAIT_LEN_RST  = 10'd48;
  localparam logic [CFG_W-1:0]   TICK_DUR_RST  = 16'd1311;
  localparam logic [CFG_W-1:0]   LIFT_PEAK_RST = 16'd1966;

  // Gait constants
  localparam logic [CYCLE_W-1:0] LEN_MIN  = 10'd6;
  localparam logic [CYCLE_W-1:0] NUM_LEGS = 10'd6;
  localparam logic [LEG_W-1:0]   NO_LEG   = 3'd6;
  // floor(n / 6) == (n * 683) >> 12 for every 10-bit n
  localparam int LEN_DIV6_MUL   = 683;
  localparam int LEN_DIV6_SHIFT = 12;

  // Serial divider
  localparam int DIV_DVD_W      = 16;
  localparam int DIV_REM_W      = SWING_W;
  localparam int DIV_CNT_W      = 5;
  localparam logic [DIV_CNT_W-1:0] LEG_DIV_STEPS  = 5'd10;
  localparam logic [DIV_CNT_W-1:0] PROG_DIV_STEPS = 5'd16;

  // Sine table generation (Q2.30 Taylor series)
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] PI_HALF_Q30 = PI_Q30 / 64'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LEG,
    ST_DIV_PROG,
    ST_ROM,
    ST_MSTART,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_DVD_W-1:0] dividend;
  } div_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quot;
    logic [DIV_REM_W-1:0] rem;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wgsg_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the leg/phase
// split and the progress division. Depends on wgsg_pkg.
`default_nettype none

module wgsg_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wgsg_pkg::div_cmd_t            cmd,
  input  wire logic [wgsg_pkg::SWING_W-1:0]  divisor,
  output wgsg_pkg::div_stat_t                stat
);

  logic [wgsg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [wgsg_pkg::DIV_DVD_W-1:0] dvd_r;
  logic [wgsg_pkg::DIV_DVD_W-1:0] quot_r;
  logic [wgsg_pkg::DIV_REM_W-1:0] rem_r;

  logic [wgsg_pkg::DIV_REM_W:0]   rem_sh;
  logic [wgsg_pkg::DIV_REM_W:0]   rem_dif;
  logic                           qbit;
  logic [wgsg_pkg::DIV_REM_W-1:0] rem_nxt;

  // One restoring step: bring down the next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_r, dvd_r[wgsg_pkg::DIV_DVD_W-1]};
    rem_dif = rem_sh - {1'b0, divisor};
    qbit    = (rem_sh >= {1'b0, divisor});
    rem_nxt = qbit ? rem_dif[wgsg_pkg::DIV_REM_W-1:0]
                   : rem_sh[wgsg_pkg::DIV_REM_W-1:0];
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (cmd.start) begin
      cnt_r  <= cmd.steps;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == wgsg_pkg::DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_r  <= cmd.dividend;
      rem_r  <= cmd.rem_init;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r  <= {dvd_r[wgsg_pkg::DIV_DVD_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[wgsg_pkg::DIV_DVD_W-2:0], qbit};
    end
  end

  assign stat.done = done_r;
  assign stat.quot = quot_r;
  assign stat.rem  = rem_r;

endmodule

`default_nettype wire

// ----- hw/rtl/wgsg_mul.sv -----
// Shift-add multiplier, unsigned, one multiplier bit per cycle (LSB first).
// Depends on no other file.
`default_nettype none

module wgsg_mul #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic                  busy,
  output logic [A_W+B_W-1:0]    product
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0]   cnt_r;
  logic [A_W-1:0]     a_r;
  logic [B_W-1:0]     b_r;
  logic [A_W+B_W-1:0] acc_r;
  logic [A_W:0]       sum;

  // Add the multiplicand into the top of the accumulator when the bit is set
  assign sum = {1'b0, acc_r[A_W+B_W-1:B_W]} + (b_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(B_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      acc_r <= {sum, acc_r[B_W-1:1]};
      b_r   <= b_r >> 1;
    end
  end

  assign busy    = (cnt_r != '0);
  assign product = acc_r;

endmodule

`default_nettype wire

// ----- hw/rtl/wgsg_sine_rom.sv -----
// Half-wave sine lookup: maps Q0.16 progress to a quarter-wave table index
// and returns the registered table entry. Depends on wgsg_pkg.
`default_nettype none

module wgsg_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic [wgsg_pkg::PROG_W-1:0]   progress,
  output logic [15:0]                        sine
);

  localparam int TWO_D  = 2 * SINE_TABLE_DEPTH;
  localparam int U_W    = $clog2(TWO_D + 1);
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = wgsg_pkg::PROG_W + U_W;

  // Entry k = sin(k*pi/(2D)) in Q0.16 from a Q2.30 Taylor series
  function automatic logic [15:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(k) * wgsg_pkg::PI_HALF_Q30) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd8192) >> 14;
    if (sum > 64'd65535) begin
      sum = 64'd65535;
    end
    return sum[15:0];
  endfunction

  logic [15:0] rom_tbl [SINE_TABLE_DEPTH+1];

  // Table contents settle at elaboration
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [15:0] ENTRY = sine_entry(k);
    assign rom_tbl[k] = ENTRY;
  end

  logic [PROD_W-1:0] u_full;
  logic [U_W-1:0]    u;
  logic [U_W-1:0]    u_mirror;
  logic [IDX_W-1:0]  idx;
  logic [15:0]       sine_r;

  // Half-wave index, folded onto the quarter wave
  always_comb begin
    u_full   = PROD_W'(progress) * PROD_W'(TWO_D);
    u        = u_full[wgsg_pkg::PROG_FRAC +: U_W];
    u_mirror = U_W'(TWO_D) - u;
    idx      = (u <= U_W'(SINE_TABLE_DEPTH)) ? u[IDX_W-1:0] : u_mirror[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    sine_r <= rom_tbl[idx];
  end

  assign sine = sine_r;

endmodule

`default_nettype wire

// ----- hw/rtl/wave_gait_swing_generator.sv -----
// Wave gait swing generator, top level: gait tick counter, control FSM,
// output register. Depends on wgsg_pkg, wgsg_div, wgsg_mul, wgsg_sine_rom.
//
// Usage: each transfer on the in_ channel is one gait tick carrying forward,
// lateral and turn velocity. Each tick yields exactly one transfer on the
// out_ channel: the swinging leg (6 = none) and its foot offsets x, y, z.
// cfg_we writes the gait length, tick duration or lift peak (cfg_index 0..2);
// write only while no tick is in flight.
// The block works on one tick at a time; in_ready returns in the cycle
// after the result is loaded. A swinging tick passes through the
// bit-serial units: 10 + 16 divider steps (leg/phase, then progress)
// and a 17-step shift-add multiply for the foot offsets; any other tick
// (standing still or a leftover tick) skips the progress division and
// the foot-offset multiply.
// A finished result sits in the output register; the next tick is taken
// while it waits, and only loading a new result waits for out_ready.
// Reset (rst_n low, synchronous) clears the tick counter, loads the
// register defaults (48, 1311, 1966) and empties the output register.
`default_nettype none

module wave_gait_swing_generator #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  // gait tick input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_vel_forward,
  input  wire logic signed [15:0] in_vel_lateral,
  input  wire logic signed [15:0] in_vel_turn,
  // swing result
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_swing_leg,
  output logic signed [23:0]      out_foot_x,
  output logic signed [23:0]      out_foot_y,
  output logic [15:0]             out_foot_z
);

  localparam int MUL1_W = 2 * wgsg_pkg::VEL_W;
  localparam int MUL2_W = MUL1_W + wgsg_pkg::PROG_W;
  localparam int MULZ_W = 2 * wgsg_pkg::FOOT_Z_W;
  localparam int RND_SH = 24;

  // Configuration registers
  logic [wgsg_pkg::CYCLE_W-1:0] gait_len_r;
  logic [wgsg_pkg::CFG_W-1:0]   tick_dur_r;
  logic [wgsg_pkg::CFG_W-1:0]   lift_peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gait_len_r  <= wgsg_pkg::GAIT_LEN_RST;
      tick_dur_r  <= wgsg_pkg::TICK_DUR_RST;
      lift_peak_r <= wgsg_pkg::LIFT_PEAK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wgsg_pkg::CFG_GAIT_LEN:  gait_len_r  <= cfg_wdata[wgsg_pkg::CYCLE_W-1:0];
        wgsg_pkg::CFG_TICK_DUR:  tick_dur_r  <= cfg_wdata;
        wgsg_pkg::CFG_LIFT_PEAK: lift_peak_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective cycle length and swing window length (len / 6)
  logic [wgsg_pkg::CYCLE_W-1:0]   len;
  logic [2*wgsg_pkg::CYCLE_W-1:0] swing_full;
  logic [wgsg_pkg::SWING_W-1:0]   swing;

  always_comb begin
    len        = (gait_len_r < wgsg_pkg::LEN_MIN) ? wgsg_pkg::LEN_MIN : gait_len_r;
    swing_full = (2*wgsg_pkg::CYCLE_W)'(len) *
                 (2*wgsg_pkg::CYCLE_W)'(wgsg_pkg::LEN_DIV6_MUL);
    swing      = swing_full[wgsg_pkg::LEN_DIV6_SHIFT +: wgsg_pkg::SWING_W];
  end

  wgsg_pkg::state_t state_r, state_nxt;
  logic accept;
  logic out_load;
  logic mul1_start;
  logic mul2_start;
  logic active_go;
  logic mul_busy;

  wgsg_pkg::div_cmd_t  div_cmd;
  wgsg_pkg::div_stat_t div_stat;

  // Tick counter, advanced on each input transfer
  logic [wgsg_pkg::CYCLE_W-1:0] tick_count_r;
  logic [wgsg_pkg::CYCLE_W:0]   tick_inc;

  assign tick_inc = {1'b0, tick_count_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
    end else if (accept) begin
      tick_count_r <= (tick_inc >= {1'b0, len}) ? '0 : tick_inc[wgsg_pkg::CYCLE_W-1:0];
    end
  end

  // Velocity magnitudes and signs
  logic [wgsg_pkg::VEL_W-1:0] mag_f;
  logic [wgsg_pkg::VEL_W-1:0] mag_l;

  assign mag_f = in_vel_forward[wgsg_pkg::VEL_W-1] ? (~in_vel_forward + 1'b1) : in_vel_forward;
  assign mag_l = in_vel_lateral[wgsg_pkg::VEL_W-1] ? (~in_vel_lateral + 1'b1) : in_vel_lateral;

  logic vf_neg_r, vl_neg_r, moving_r, active_r, p_hi_r;
  logic [wgsg_pkg::LEG_W-1:0]  leg_r;
  logic [wgsg_pkg::PROG_W-1:0] p_r;

  // Progress division setup from the phase
  logic [wgsg_pkg::SWING_W-1:0] ph1;
  logic                         p_hi;

  always_comb begin
    ph1       = div_stat.rem + 1'b1;
    p_hi      = (ph1 == swing);
    active_go = moving_r &&
                (div_stat.quot[wgsg_pkg::CYCLE_W-1:0] < wgsg_pkg::NUM_LEGS);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vf_neg_r <= in_vel_forward[wgsg_pkg::VEL_W-1];
      vl_neg_r <= in_vel_lateral[wgsg_pkg::VEL_W-1];
      moving_r <= (in_vel_forward != '0) || (in_vel_lateral != '0) || (in_vel_turn != '0);
    end
    if (state_r == wgsg_pkg::ST_DIV_LEG && div_stat.done) begin
      active_r <= active_go;
      leg_r    <= div_stat.quot[wgsg_pkg::LEG_W-1:0];
      p_hi_r   <= p_hi;
    end
    if (state_r == wgsg_pkg::ST_DIV_PROG && div_stat.done) begin
      p_r <= {p_hi_r, div_stat.quot};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wgsg_pkg::ST_IDLE:     if (accept) state_nxt = wgsg_pkg::ST_DIV_LEG;
      wgsg_pkg::ST_DIV_LEG: begin
        if (div_stat.done) begin
          state_nxt = active_go ? wgsg_pkg::ST_DIV_PROG : wgsg_pkg::ST_DONE;
        end
      end
      wgsg_pkg::ST_DIV_PROG: if (div_stat.done) state_nxt = wgsg_pkg::ST_ROM;
      wgsg_pkg::ST_ROM:      state_nxt = wgsg_pkg::ST_MSTART;
      wgsg_pkg::ST_MSTART:   state_nxt = wgsg_pkg::ST_MUL;
      wgsg_pkg::ST_MUL:      if (!mul_busy) state_nxt = wgsg_pkg::ST_DONE;
      wgsg_pkg::ST_DONE:     if (out_load) state_nxt = wgsg_pkg::ST_IDLE;
      default:               state_nxt = wgsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wgsg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // FSM outputs
  always_comb begin
    in_ready         = 1'b0;
    mul1_start       = 1'b0;
    mul2_start       = 1'b0;
    out_load         = 1'b0;
    div_cmd.start    = 1'b0;
    div_cmd.steps    = wgsg_pkg::LEG_DIV_STEPS;
    div_cmd.rem_init = '0;
    div_cmd.dividend = {tick_count_r, {(wgsg_pkg::DIV_DVD_W-wgsg_pkg::CYCLE_W){1'b0}}};
    unique case (state_r)
      wgsg_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        mul1_start    = in_valid;
        div_cmd.start = in_valid;
      end
      wgsg_pkg::ST_DIV_LEG: begin
        div_cmd.start    = div_stat.done && active_go;
        div_cmd.steps    = wgsg_pkg::PROG_DIV_STEPS;
        div_cmd.rem_init = p_hi ? '0 : ph1;
        div_cmd.dividend = '0;
      end
      wgsg_pkg::ST_MSTART: begin
        mul2_start = 1'b1;
      end
      wgsg_pkg::ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      wgsg_pkg::ST_DIV_PROG, wgsg_pkg::ST_ROM, wgsg_pkg::ST_MUL: ;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  wgsg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (div_cmd),
    .divisor (swing),
    .stat    (div_stat)
  );

  logic [15:0] sine;

  wgsg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk      (clk),
    .progress (p_r),
    .sine     (sine)
  );

  // |v| * tick duration, runs while the divider works
  logic [MUL1_W-1:0] vs_x, vs_y;
  logic              busy_x1, busy_y1;

  wgsg_mul #(.A_W(wgsg_pkg::CFG_W), .B_W(wgsg_pkg::VEL_W)) u_mul_x1 (
    .clk (clk), .rst_n (rst_n), .start (mul1_start),
    .a (tick_dur_r), .b (mag_f), .busy (busy_x1), .product (vs_x)
  );

  wgsg_mul #(.A_W(wgsg_pkg::CFG_W), .B_W(wgsg_pkg::VEL_W)) u_mul_y1 (
    .clk (clk), .rst_n (rst_n), .start (mul1_start),
    .a (tick_dur_r), .b (mag_l), .busy (busy_y1), .product (vs_y)
  );

  // Scale by progress, lift by sine
  logic [MUL2_W-1:0] prod_x, prod_y;
  logic [MULZ_W-1:0] prod_z;
  logic              busy_x2, busy_y2, busy_z;

  wgsg_mul #(.A_W(MUL1_W), .B_W(wgsg_pkg::PROG_W)) u_mul_x2 (
    .clk (clk), .rst_n (rst_n), .start (mul2_start),
    .a (vs_x), .b (p_r), .busy (busy_x2), .product (prod_x)
  );

  wgsg_mul #(.A_W(MUL1_W), .B_W(wgsg_pkg::PROG_W)) u_mul_y2 (
    .clk (clk), .rst_n (rst_n), .start (mul2_start),
    .a (vs_y), .b (p_r), .busy (busy_y2), .product (prod_y)
  );

  wgsg_mul #(.A_W(wgsg_pkg::CFG_W), .B_W(wgsg_pkg::FOOT_Z_W)) u_mul_z (
    .clk (clk), .rst_n (rst_n), .start (mul2_start),
    .a (lift_peak_r), .b (sine), .busy (busy_z), .product (prod_z)
  );

  assign mul_busy = busy_x1 || busy_y1 || busy_x2 || busy_y2 || busy_z;

  // Round to nearest (ties away from zero on the magnitude), then apply sign
  logic [MUL2_W-1:0]             rnd_x, rnd_y;
  logic [wgsg_pkg::FOOT_XY_W-1:0] mag_x, mag_y, foot_x, foot_y;

  always_comb begin
    rnd_x  = prod_x + (MUL2_W'(1) << (RND_SH - 1));
    rnd_y  = prod_y + (MUL2_W'(1) << (RND_SH - 1));
    mag_x  = rnd_x[RND_SH +: wgsg_pkg::FOOT_XY_W];
    mag_y  = rnd_y[RND_SH +: wgsg_pkg::FOOT_XY_W];
    foot_x = vf_neg_r ? (~mag_x + 1'b1) : mag_x;
    foot_y = vl_neg_r ? (~mag_y + 1'b1) : mag_y;
  end

  // Output register
  logic                            out_valid_r;
  logic [wgsg_pkg::LEG_W-1:0]      out_leg_r;
  logic [wgsg_pkg::FOOT_XY_W-1:0]  out_x_r, out_y_r;
  logic [wgsg_pkg::FOOT_Z_W-1:0]   out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (active_r) begin
        out_leg_r <= leg_r;
        out_x_r   <= foot_x;
        out_y_r   <= foot_y;
        out_z_r   <= prod_z[wgsg_pkg::FOOT_Z_W +: wgsg_pkg::FOOT_Z_W];
      end else begin
        out_leg_r <= wgsg_pkg::NO_LEG;
        out_x_r   <= '0;
        out_y_r   <= '0;
        out_z_r   <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_swing_leg = out_leg_r;
  assign out_foot_x    = out_x_r;
  assign out_foot_y    = out_y_r;
  assign out_foot_z    = out_z_r;

endmodule

`default_nettype wire
